FILE: sv/csc_pkg.sv
// Shared types for the Collatz step count search block.
// Holds the transaction payload structs and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package csc_pkg;

  // Fixed field widths of the transaction payloads.
  localparam int START_FIELD_W = 32;
  localparam int COUNT_FIELD_W = 16;

  // Input transaction: one start value and a restart flag.
  typedef struct packed {
    logic [START_FIELD_W-1:0] start_value;
    logic                     restart;
  } csc_in_t;

  // Result transaction: this item's count and the running best.
  typedef struct packed {
    logic [COUNT_FIELD_W-1:0] step_count;
    logic                     overflowed;
    logic [COUNT_FIELD_W-1:0] best_count;
    logic [START_FIELD_W-1:0] best_start;
  } csc_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } csc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic term;
  } csc_stat_t;

endpackage

`default_nettype wire

FILE: sv/collatz_step_count_max_search.sv
// Top level of the Collatz step count search with running best.
// Instantiates csc_ctrl and csc_dp; depends on csc_pkg.
//
//   Channel   Ports                          Payload type
//   input     in_valid / in_ready / in_data  csc_pkg::csc_in_t
//   result    out_valid/out_ready/out_data   csc_pkg::csc_out_t
//
// An item is loaded, then advanced by one Collatz step per cycle, and a
// final step writes the result; all steps use the single step unit in the
// datapath. Starts 0 and 2 go straight from the load to the final step.
// Reset is synchronous on rst_n low and clears the best count and start.
// A result waiting on out_ready holds the run in its final step; a new item
// is taken as soon as the previous one has written its result.
`default_nettype none

module collatz_step_count_max_search #(
  parameter int START_WIDTH = 32,
  parameter int VALUE_WIDTH = 64,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire csc_pkg::csc_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output csc_pkg::csc_out_t      out_data
);
  import csc_pkg::*;

  csc_cmd_t  cmd;
  csc_stat_t stat;

  csc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  csc_dp #(
    .START_WIDTH (START_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

FILE: sv/csc_dp.sv
// Datapath of the Collatz step count search: trajectory value, step counter,
// best count tracking and the result register. Depends on csc_pkg.
`default_nettype none

module csc_dp #(
  parameter int START_WIDTH = 32,
  parameter int VALUE_WIDTH = 64,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire csc_pkg::csc_in_t   in_data,
  input  wire csc_pkg::csc_cmd_t  cmd,
  output csc_pkg::csc_stat_t      stat,
  output csc_pkg::csc_out_t       out_data
);
  import csc_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int CW = COUNT_WIDTH;

  // Largest value allowed in the signed value range, and the largest
  // value whose 3n+1 still fits in it.
  localparam logic [VW-1:0] VALUE_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] CUT_LIMIT = VW'((VALUE_MAX - 1) / 3);
  localparam logic [START_FIELD_W-1:0] START_MASK =
    (START_WIDTH >= START_FIELD_W) ? {START_FIELD_W{1'b1}}
                                   : START_FIELD_W'((64'd1 << START_WIDTH) - 64'd1);
  localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

  logic [VW-1:0]            value_r;
  logic [CW-1:0]            count_r;
  logic                     ovf_r;
  logic [START_FIELD_W-1:0] start_r;
  logic [CW-1:0]            best_count_r;
  logic [START_FIELD_W-1:0] best_start_r;
  csc_out_t                 out_r;

  logic [START_FIELD_W-1:0] start_m;
  logic                     too_wide;
  logic [VW-1:0]            half;
  logic [VW-1:0]            triple;
  logic                     is_odd;
  logic                     cut;
  logic [CW-1:0]            count_inc;
  logic [CW-1:0]            final_count;
  logic                     final_ovf;
  logic                     best_wins;
  logic [CW-1:0]            best_base;
  logic [31:0]              final_count32;
  logic [31:0]              best_count32;

  // Start value cut to its configured width and the range check on it.
  assign start_m  = in_data.start_value & START_MASK;
  assign too_wide = 64'(start_m) > 64'(VALUE_MAX);

  // One Collatz step on the current value.
  assign is_odd = value_r[0];
  assign half   = value_r >> 1;
  assign triple = (value_r << 1) + value_r + VW'(1);
  assign cut    = is_odd && (value_r > CUT_LIMIT);

  // The run ends on a zero value, on a halving that yields one, or on a cut.
  assign stat.term = (value_r == '0) || (!is_odd && (half == VW'(1))) || cut;

  // Saturating step counter increment.
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + CW'(1);

  // Final figures of the item; a cut step is still counted.
  assign final_count = cut ? count_inc : count_r;
  assign final_ovf   = ovf_r | cut;
  assign best_wins   = final_count > best_base;
  assign best_base   = best_count_r;

  assign final_count32 = 32'(final_count);
  assign best_count32  = best_wins ? 32'(final_count) : 32'(best_count_r);

  // Trajectory registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      count_r <= '0;
      ovf_r   <= 1'b0;
      value_r <= '0;
    end else if (cmd.load) begin
      start_r <= start_m;
      count_r <= '0;
      ovf_r   <= too_wide;
      value_r <= too_wide ? '0 : VW'(start_m);
    end else if (cmd.step) begin
      value_r <= is_odd ? triple : half;
      count_r <= count_inc;
    end
  end

  // Best count and its start; restart clears them as the item is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_count_r <= '0;
      best_start_r <= '0;
    end else if (cmd.load && in_data.restart) begin
      best_count_r <= '0;
      best_start_r <= '0;
    end else if (cmd.finish && best_wins) begin
      best_count_r <= final_count;
      best_start_r <= start_r;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r.step_count <= final_count32[COUNT_FIELD_W-1:0];
      out_r.overflowed <= final_ovf;
      out_r.best_count <= best_count32[COUNT_FIELD_W-1:0];
      out_r.best_start <= best_wins ? start_r : best_start_r;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

FILE: sv/csc_ctrl.sv
// Controller of the Collatz step count search: sequences load, step and finish
// and owns the handshake flags. Depends on csc_pkg.
`default_nettype none

module csc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire csc_pkg::csc_stat_t stat,
  output csc_pkg::csc_cmd_t       cmd
);
  import csc_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // The result register can take a new result when empty or being drained.
  assign slot_free = !out_valid_r || out_ready;

  // Commands to the datapath.
  always_comb begin
    cmd.load   = (state_r == S_IDLE) && in_valid;
    cmd.step   = (state_r == S_RUN) && !stat.term;
    cmd.finish = (state_r == S_RUN) && stat.term && slot_free;
  end

  // Next state and result flag.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (cmd.finish) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // A result is only written into a free result register.
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("result written over a pending transaction");

  // A finished item is presented in the next cycle.
  a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid)
    else $error("finished item not presented");

  // After taking an item the block is busy.
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in work");

  // No step is taken on a terminal value.
  a_no_step_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !stat.term)
    else $error("step issued at end of trajectory");

endmodule

`default_nettype wire
